### hdl/dlb_pkg.sv
// shared constants, register indexes and control structs of the decimating lag basis filter bank
package dlb_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int MAX_BASIS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    localparam int SUM_BITS      = 40;
    localparam int WEND_BITS     = 32;
    localparam int ROW_BITS      = 3;
    localparam int TAP_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int DEC_BITS      = 9;
    localparam int PHASE_BITS    = 8;
    localparam int WTAPS_BITS    = 6;
    localparam int BCOUNT_BITS   = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DECIMATION  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TAPS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASIS_COUNT = 2'd3;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic take_sample;
        logic take_coef;
        logic row_start;
        logic issue;
        logic push;
    } dlb_cmd_t;

    typedef struct packed {
        logic emit;
        logic tap_last;
        logic row_last;
        logic acc_done;
        logic out_busy;
    } dlb_stat_t;

endpackage

### hdl/dlb_ctrl.sv
// controller state machine: item intake, row sweep sequencing and result hand-off
module dlb_ctrl
    import dlb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      kind,
    input  dlb_stat_t stat,
    output logic      in_ready,
    output dlb_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ROW,
        ST_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_SAMPLE)
                    begin
                        cmd.take_sample = 1'b1;
                        if (stat.emit)
                        begin
                            state_next = ST_START;
                        end
                    end
                    else
                    begin
                        cmd.take_coef = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                cmd.row_start = 1'b1;
                state_next    = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.issue = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (stat.acc_done && !stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = stat.row_last ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/dlb_dp.sv
// datapath: config registers, sample window, coefficient table, shared mac and result register
module dlb_dp
    import dlb_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int MAX_BASIS   = MAX_BASIS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [ROW_BITS-1:0]            coef_row,
    input  logic [TAP_BITS-1:0]            coef_tap,
    input  logic signed [COEF_BITS-1:0]    coef_value,
    input  dlb_cmd_t                       cmd,
    output dlb_stat_t                      stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ROW_BITS-1:0]            row_index,
    output logic signed [SUM_BITS-1:0]     sum_value,
    output logic [WEND_BITS-1:0]           window_end,
    output logic                           last
);

    localparam int TAP_AW  = $clog2(MAX_TAPS);
    localparam int ROW_AW  = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int DEPTH   = MAX_BASIS * MAX_TAPS;
    localparam int CADDR_W = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_W   = ((PROD_W > SUM_BITS) ? PROD_W : SUM_BITS) + 1;

    localparam logic [TAP_AW-1:0] LAST_SLOT = TAP_AW'(MAX_TAPS - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(MAX_TAPS);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(SUM_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // config registers
    logic [DEC_BITS-1:0]    decimation_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [WTAPS_BITS-1:0]  window_taps_reg;
    logic [BCOUNT_BITS-1:0] basis_count_reg;

    // stream state
    logic [TAP_AW-1:0]      head_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [WEND_BITS-1:0]   count_reg;
    logic [PHASE_BITS-1:0]  dcnt_reg;
    logic [WEND_BITS-1:0]   end_reg;

    // sweep state
    logic [ROW_AW-1:0]      row_reg;
    logic [TAP_AW-1:0]      k_reg;
    logic [TAP_AW-1:0]      slot_reg;
    logic                   p1_valid_reg;
    logic                   p1_first_reg;
    logic                   p1_last_reg;
    logic                   p2_valid_reg;
    logic                   p2_first_reg;
    logic                   p2_last_reg;
    logic                   acc_done_reg;
    logic signed [SAMPLE_BITS-1:0] s_rd_reg;
    logic signed [COEF_BITS-1:0]   c_rd_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SUM_BITS-1:0]    acc_reg;
    logic signed [SUM_BITS-1:0]    acc_next;

    // result register
    logic                   out_valid_reg;
    logic [ROW_BITS-1:0]    row_index_reg;
    logic signed [SUM_BITS-1:0] sum_value_reg;
    logic [WEND_BITS-1:0]   window_end_reg;
    logic                   last_reg;

    logic signed [SAMPLE_BITS-1:0] smem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   cmem [DEPTH];

    logic [DEC_BITS-1:0]    dec_eff;
    logic [DEC_BITS-1:0]    dec_m1;
    logic [DEC_BITS-1:0]    ph_eff;
    logic [TAP_AW-1:0]      taps_eff;
    logic [ROW_AW-1:0]      rows_m1;
    logic [FILL_W-1:0]      fill_next;
    logic                   full;
    logic [PHASE_BITS-1:0]  dcnt_next;
    logic [TAP_AW-1:0]      head_next;
    logic [TAP_AW-1:0]      slot_start;
    logic [TAP_AW-1:0]      slot_next;
    logic [CADDR_W-1:0]     caddr_rd;
    logic [CADDR_W-1:0]     caddr_wr;
    logic                   coef_ok;
    logic signed [SUM_W-1:0] sum_wide;

    // clamped register views
    always_comb
    begin
        if (decimation_reg == '0)
        begin
            dec_eff = DEC_BITS'(1);
        end
        else if (decimation_reg > DEC_BITS'(256))
        begin
            dec_eff = DEC_BITS'(256);
        end
        else
        begin
            dec_eff = decimation_reg;
        end
        dec_m1 = dec_eff - DEC_BITS'(1);
        ph_eff = ({1'b0, phase_reg} > dec_m1) ? dec_m1 : {1'b0, phase_reg};

        if (32'(window_taps_reg) > 32'(MAX_TAPS - 1))
        begin
            taps_eff = LAST_SLOT;
        end
        else
        begin
            taps_eff = TAP_AW'(window_taps_reg);
        end

        if (basis_count_reg == '0)
        begin
            rows_m1 = '0;
        end
        else if (32'(basis_count_reg) > 32'(MAX_BASIS))
        begin
            rows_m1 = ROW_AW'(MAX_BASIS - 1);
        end
        else
        begin
            rows_m1 = ROW_AW'(basis_count_reg - BCOUNT_BITS'(1));
        end
    end

    // decimation decision for an incoming sample
    always_comb
    begin
        fill_next = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FILL_W'(1);
        full      = 32'(fill_next) > 32'(taps_eff);
        if (!full)
        begin
            dcnt_next = '0;
        end
        else if (({1'b0, dcnt_reg} + DEC_BITS'(1)) >= dec_eff)
        begin
            dcnt_next = '0;
        end
        else
        begin
            dcnt_next = dcnt_reg + PHASE_BITS'(1);
        end
        head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + TAP_AW'(1);
        slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + TAP_AW'(1);
        if (head_reg >= taps_eff)
        begin
            slot_start = head_reg - taps_eff;
        end
        else
        begin
            slot_start = TAP_AW'({1'b0, head_reg} + (TAP_AW+1)'(MAX_TAPS) - {1'b0, taps_eff});
        end
    end

    assign caddr_rd = CADDR_W'(row_reg) * CADDR_W'(MAX_TAPS) + CADDR_W'(k_reg);
    assign caddr_wr = CADDR_W'(coef_row) * CADDR_W'(MAX_TAPS) + CADDR_W'(coef_tap);
    assign coef_ok  = (32'(coef_row) < 32'(MAX_BASIS)) && (32'(coef_tap) < 32'(MAX_TAPS));

    // saturating accumulate
    always_comb
    begin
        if (p2_first_reg)
        begin
            sum_wide = SUM_W'(prod_reg);
        end
        else
        begin
            sum_wide = SUM_W'(acc_reg) + SUM_W'(prod_reg);
        end
        if (sum_wide > SAT_MAX)
        begin
            acc_next = SUM_BITS'(SAT_MAX);
        end
        else if (sum_wide < SAT_MIN)
        begin
            acc_next = SUM_BITS'(SAT_MIN);
        end
        else
        begin
            acc_next = sum_wide[SUM_BITS-1:0];
        end
    end

    always_comb
    begin
        stat.emit     = full && ({1'b0, dcnt_reg} == ph_eff);
        stat.tap_last = (k_reg == taps_eff);
        stat.row_last = (row_reg == rows_m1);
        stat.acc_done = acc_done_reg;
        stat.out_busy = out_valid_reg && !out_ready;
    end

    // sample window and coefficient table
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            smem[head_next] <= sample;
        end
        s_rd_reg <= smem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_coef && coef_ok)
        begin
            cmem[caddr_wr] <= coef_value;
        end
        c_rd_reg <= cmem[caddr_rd];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= c_rd_reg * s_rd_reg;
        if (p2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.take_sample)
        begin
            end_reg <= count_reg;
        end
        if (cmd.push)
        begin
            row_index_reg  <= ROW_BITS'(row_reg);
            sum_value_reg  <= acc_reg;
            window_end_reg <= end_reg;
            last_reg       <= stat.row_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimation_reg  <= DEC_BITS'(1);
            phase_reg       <= '0;
            window_taps_reg <= '0;
            basis_count_reg <= BCOUNT_BITS'(1);
            head_reg        <= '0;
            fill_reg        <= '0;
            count_reg       <= '0;
            dcnt_reg        <= '0;
            row_reg         <= '0;
            k_reg           <= '0;
            slot_reg        <= '0;
            p1_valid_reg    <= 1'b0;
            p1_first_reg    <= 1'b0;
            p1_last_reg     <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p2_first_reg    <= 1'b0;
            p2_last_reg     <= 1'b0;
            acc_done_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DECIMATION:  decimation_reg  <= cfg_data[DEC_BITS-1:0];
                    CFG_PHASE:       phase_reg       <= cfg_data[PHASE_BITS-1:0];
                    CFG_WINDOW_TAPS: window_taps_reg <= cfg_data[WTAPS_BITS-1:0];
                    CFG_BASIS_COUNT: basis_count_reg <= cfg_data[BCOUNT_BITS-1:0];
                    default:         decimation_reg  <= decimation_reg;
                endcase
            end

            if (cmd.take_sample)
            begin
                head_reg  <= head_next;
                fill_reg  <= fill_next;
                count_reg <= count_reg + WEND_BITS'(1);
                dcnt_reg  <= dcnt_next;
                row_reg   <= '0;
            end
            else if (cmd.push)
            begin
                row_reg <= row_reg + ROW_AW'(1);
            end

            if (cmd.row_start)
            begin
                k_reg    <= '0;
                slot_reg <= slot_start;
            end
            else if (cmd.issue)
            begin
                k_reg    <= k_reg + TAP_AW'(1);
                slot_reg <= slot_next;
            end

            p1_valid_reg <= cmd.issue;
            p1_first_reg <= (k_reg == '0);
            p1_last_reg  <= stat.tap_last;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;

            if (cmd.row_start)
            begin
                acc_done_reg <= 1'b0;
            end
            else if (p2_valid_reg && p2_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = row_index_reg;
    assign sum_value  = sum_value_reg;
    assign window_end = window_end_reg;
    assign last       = last_reg;

endmodule

### hdl/decimating_lag_basis_filter_bank_core.sv
// top level of the decimating lag basis filter bank
//
// input channel (in_valid/in_ready) carries one item per handshake: kind 0 writes one
// coefficient of the table, kind 1 pushes a new sample into the window. a coefficient
// item or a non-emitting sample keeps in_ready high, so such items flow back to back.
// an emitting sample starts a sweep of the single shared multiply-accumulate over the
// window: basis_count rows of window_taps+1 taps each, one tap per cycle, with each row
// finished by the table read, multiply and hand-off. in_ready stays low for the whole sweep.
// output channel (out_valid/out_ready) gives one item per basis row in row order, with
// last set on the final row. a result register sits between the mac and the port; a
// stalled receiver holds the sweep before the next row is handed off, and the next input
// item is taken while the final result still waits.
// configuration writes (cfg_we) take effect at once and are meant for idle periods.
// reset clears the window fill count, sample counter and decimation counter and loads
// the register defaults; the coefficient table keeps whatever it held and must be written
// before use. no clearing pass is needed, so items are taken right after reset.
module decimating_lag_basis_filter_bank_core
    import dlb_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int MAX_BASIS   = MAX_BASIS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [ROW_BITS-1:0]            coef_row,
    input  logic [TAP_BITS-1:0]            coef_tap,
    input  logic signed [COEF_BITS-1:0]    coef_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ROW_BITS-1:0]            row_index,
    output logic signed [SUM_BITS-1:0]     sum_value,
    output logic [WEND_BITS-1:0]           window_end,
    output logic                           last
);

    dlb_cmd_t  cmd;
    dlb_stat_t stat;

    dlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    dlb_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .MAX_BASIS   (MAX_BASIS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .coef_row   (coef_row),
        .coef_tap   (coef_tap),
        .coef_value (coef_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .row_index  (row_index),
        .sum_value  (sum_value),
        .window_end (window_end),
        .last       (last)
    );

`ifndef SYNTHESIS
    // a result is never loaded over one the receiver has not taken
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.out_busy)
        else $error("result register overwritten");

    // an emitting sample closes the input until its sweep is done
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_SAMPLE) && stat.emit) |=> !in_ready)
        else $error("input taken during sweep");

    // taps are only issued while the row accumulation is still open
    a_issue_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !stat.acc_done)
        else $error("tap issued after row completed");
`endif

endmodule

### verif/decimating_lag_basis_filter_bank_core_tb.sv
// testbench for the decimating lag basis filter bank core, checking every dot product it emits
`timescale 1ns / 100ps

module decimating_lag_basis_filter_bank_core_tb;
    import dlb_pkg::*;

    localparam int SWEEP_CYCLES = MAX_BASIS_DEF * (MAX_TAPS_DEF + 4) + 1;
    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;

    typedef struct {
        logic                              k;
        logic signed [SAMPLE_BITS_DEF-1:0] smp;
        logic [ROW_BITS-1:0]               row;
        logic [TAP_BITS-1:0]               tap;
        logic signed [COEF_BITS_DEF-1:0]   coef;
    } bank_item_t;

    typedef struct {
        logic [ROW_BITS-1:0]        row;
        logic signed [SUM_BITS-1:0] sum;
        logic [WEND_BITS-1:0]       wend;
        logic                       lst;
    } row_sum_t;

    class dot_product_board;
        logic [DEC_BITS-1:0]               decimation  = 1;
        logic [PHASE_BITS-1:0]             phase       = 0;
        logic [WTAPS_BITS-1:0]             window_taps = 0;
        logic [BCOUNT_BITS-1:0]            basis_count = 1;
        logic signed [SAMPLE_BITS_DEF-1:0] history [MAX_TAPS_DEF];
        logic signed [COEF_BITS_DEF-1:0]   coef_mem [MAX_BASIS_DEF*MAX_TAPS_DEF];
        logic [WEND_BITS-1:0]              sample_index = 0;
        int dec_count = 0;
        int fill = 0;
        int head = 0;
        row_sum_t pending_sums[$];
        int errors = 0;
        int samples = 0;
        int coef_writes = 0;
        int windows = 0;
        int checked = 0;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_DECIMATION:  decimation  = data[DEC_BITS-1:0];
                CFG_PHASE:       phase       = data[PHASE_BITS-1:0];
                CFG_WINDOW_TAPS: window_taps = data[WTAPS_BITS-1:0];
                CFG_BASIS_COUNT: basis_count = data[BCOUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint row_sum(int r, int taps);
            longint acc;
            int slot;
            acc = 0;
            for (int k = 0; k <= taps; k++)
            begin
                slot = (head - (taps - k) + MAX_TAPS_DEF) % MAX_TAPS_DEF;
                acc += longint'(coef_mem[r * MAX_TAPS_DEF + k]) * longint'(history[slot]);
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
            end
            return acc;
        endfunction

        function void note_item(bank_item_t it);
            int dec;
            int ph;
            int taps;
            int rows;
            bit emit;
            longint acc;
            row_sum_t res;
            if (it.k == KIND_COEF)
            begin
                coef_mem[it.row * MAX_TAPS_DEF + it.tap] = it.coef;
                coef_writes++;
                return;
            end
            samples++;
            dec  = (decimation == 0) ? 1 : ((decimation > 256) ? 256 : int'(decimation));
            ph   = (phase > dec - 1) ? dec - 1 : int'(phase);
            taps = window_taps;
            rows = (basis_count == 0) ? 1 :
                   ((basis_count > MAX_BASIS_DEF) ? MAX_BASIS_DEF : int'(basis_count));
            head = (head + 1) % MAX_TAPS_DEF;
            history[head] = it.smp;
            res.wend = sample_index;
            sample_index++;
            if (fill < MAX_TAPS_DEF)
                fill++;
            emit = 1'b0;
            if (fill < taps + 1)
                dec_count = 0;
            else
            begin
                emit = (dec_count == ph);
                dec_count = (dec_count + 1 >= dec) ? 0 : dec_count + 1;
            end
            if (!emit)
                return;
            windows++;
            for (int r = 0; r < rows; r++)
            begin
                acc = row_sum(r, taps);
                res.row = ROW_BITS'(r);
                res.sum = acc[SUM_BITS-1:0];
                res.lst = (r + 1 == rows);
                pending_sums.push_back(res);
            end
        endfunction

        task check_result(logic [ROW_BITS-1:0] row, logic signed [SUM_BITS-1:0] sum,
                          logic [WEND_BITS-1:0] wend, logic lst);
            row_sum_t want;
            checked++;
            if (pending_sums.size() == 0)
            begin
                report($sformatf("unexpected result row %0d sum %0d window end %0d",
                                 row, sum, wend));
                return;
            end
            want = pending_sums.pop_front();
            if (row !== want.row)
                report($sformatf("row_index %0d, expected %0d", row, want.row));
            if (sum !== want.sum)
                report($sformatf("sum_value %0d, expected %0d (row %0d, window end %0d)",
                                 sum, want.sum, want.row, want.wend));
            if (wend !== want.wend)
                report($sformatf("window_end %0d, expected %0d", wend, want.wend));
            if (lst !== want.lst)
                report($sformatf("last %b, expected %b (row %0d)", lst, want.lst, want.row));
        endtask

        task finish_check();
            if (pending_sums.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_sums.size()));
        endtask
    endclass

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0]           cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]          cfg_data   = '0;
    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic                              kind       = KIND_SAMPLE;
    logic signed [SAMPLE_BITS_DEF-1:0] sample     = '0;
    logic [ROW_BITS-1:0]               coef_row   = '0;
    logic [TAP_BITS-1:0]               coef_tap   = '0;
    logic signed [COEF_BITS_DEF-1:0]   coef_value = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic [ROW_BITS-1:0]               row_index;
    logic signed [SUM_BITS-1:0]        sum_value;
    logic [WEND_BITS-1:0]              window_end;
    logic                              last;

    dot_product_board board;
    int send_pct   = 0;
    int stall_pct  = 0;
    int ready_hold = 0;
    int settings   = 1;

    decimating_lag_basis_filter_bank_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample     (sample),
        .coef_row   (coef_row),
        .coef_tap   (coef_tap),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .sum_value  (sum_value),
        .window_end (window_end),
        .last       (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len(int pct);
        if ($urandom_range(99, 0) >= pct)
            return 0;
        if ($urandom_range(9, 0) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] extreme_value();
        case ($urandom_range(3, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    function automatic bank_item_t make_item(logic k, int smp, int row, int tap, int coef);
        bank_item_t it;
        it.k    = k;
        it.smp  = SAMPLE_BITS_DEF'(smp);
        it.row  = ROW_BITS'(row);
        it.tap  = TAP_BITS'(tap);
        it.coef = COEF_BITS_DEF'(coef);
        return it;
    endfunction

    function automatic bank_item_t rand_item(int coef_pct);
        bank_item_t it;
        it.k    = ($urandom_range(99, 0) < coef_pct) ? KIND_COEF : KIND_SAMPLE;
        it.smp  = ($urandom_range(9, 0) == 0) ? extreme_value() : SAMPLE_BITS_DEF'($urandom);
        it.row  = ROW_BITS'($urandom);
        it.tap  = TAP_BITS'($urandom);
        it.coef = ($urandom_range(9, 0) == 0) ? extreme_value() : COEF_BITS_DEF'($urandom);
        return it;
    endfunction

    // receiver side: random stalls on the result channel
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (out_ready && $urandom_range(99, 0) < stall_pct)
        begin
            ready_hold <= idle_len(100);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
        if (out_valid && out_ready)
            board.check_result(row_index, sum_value, window_end, last);

    task automatic send_item(input bank_item_t it);
        int gap;
        gap = idle_len(send_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= it.k;
        sample     <= it.smp;
        coef_row   <= it.row;
        coef_tap   <= it.tap;
        coef_value <= it.coef;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(it);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_sums.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_BITS-1:0];
        @(posedge clk);
        board.set_reg(idx, data[CFG_DATA_BITS-1:0]);
    endtask

    task automatic run_phase(input int dec, input int ph, input int taps, input int bc,
                             input int count, input int coef_pct, input int spct,
                             input int rpct);
        wait_results();
        // a trailing item without results may still be in the sweep
        repeat (SWEEP_CYCLES + 16) @(posedge clk);
        write_reg(CFG_DECIMATION, dec);
        write_reg(CFG_PHASE, ph);
        write_reg(CFG_WINDOW_TAPS, taps);
        write_reg(CFG_BASIS_COUNT, bc);
        cfg_we <= 1'b0;
        settings++;
        send_pct  = spct;
        stall_pct = rpct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(49, 0) == 0)
                wait_results();
            send_item(rand_item(coef_pct));
        end
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: single tap, single row, every sample emits
        send_pct  = 20;
        stall_pct = 20;
        send_item(make_item(KIND_COEF, 0, 0, 0, -32768));
        send_item(make_item(KIND_SAMPLE, -32768, 0, 0, 0));
        send_item(make_item(KIND_SAMPLE, 32767, 7, 63, -1));
        send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0));
        send_item(make_item(KIND_COEF, -1, 0, 0, 32767));
        send_item(make_item(KIND_SAMPLE, -32768, 0, 0, 0));
        send_item(make_item(KIND_SAMPLE, 32767, 0, 0, 0));
        send_item(make_item(KIND_SAMPLE, -1, 0, 0, 0));
        send_item(make_item(KIND_SAMPLE, 1, 0, 0, 0));
        send_item(make_item(KIND_COEF, 0, 7, 63, -32768));
        send_item(make_item(KIND_COEF, 0, 0, 63, 32767));

        // every row for the first eight taps, row 0 for the rest of the window
        send_pct = 10;
        for (int t = 0; t < MAX_TAPS_DEF; t++)
            for (int r = 0; r < ((t < 8) ? MAX_BASIS_DEF : 1); r++)
                send_item(make_item(KIND_COEF, $urandom, r, t,
                                    ($urandom_range(7, 0) == 0) ? extreme_value() : $urandom));

        run_phase(3, 1, 5, 2, 10, 20, 30, 30);
        run_phase(2, 1, 0, 5, 10, 15, 0, 0);
        run_phase(1, 0, 63, 1, 12, 10, 30, 15);
        run_phase(511, 1, 2, 0, 8, 5, 40, 40);
        run_phase(0, 0, 7, 15, 10, 10, 20, 30);
        run_phase(256, 0, 10, 1, 8, 0, 30, 30);
        run_phase(4, 255, 63, 1, 10, 10, 30, 30);
        repeat (4)
            run_phase($urandom_range(6, 1), $urandom_range(5, 0), $urandom_range(7, 0),
                      $urandom_range(8, 1), 7, 15, 30, 30);

        wait_results();
        repeat (SWEEP_CYCLES) @(posedge clk);
        board.finish_check();

        $display("covered %0d items (%0d samples, %0d coefficient writes) under %0d settings",
                 board.samples + board.coef_writes, board.samples, board.coef_writes, settings);
        $display("checked %0d results from %0d emitting windows", board.checked, board.windows);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout, %0d results still expected", board.pending_sums.size());
        $display("FAIL");
        $finish;
    end

endmodule
